// ===== sv/assert_macros.svh =====
// Assertion macros shared by the dedup block's RTL files.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/fpdr_pkg.sv =====
// Shared types and constants of the feature point dedup block.
// Used by the controller, the datapath and the top level; depends on nothing.
package fpdr_pkg;

  localparam int COORD_W     = 16;
  localparam int IDX_W       = 20;
  localparam int KEPT_W      = 10;
  localparam int OP_W        = 2;
  localparam int SQ_W        = 2 * COORD_W;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 1;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 20;

  localparam logic [COORD_W-1:0] THRESH_RESET = 16'd240;
  localparam logic [IDX_W-1:0]   FIRST_RESET  = 20'd0;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_INDEX = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  // Controller to datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic start;
    logic issue;
    logic emit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic empty;
    logic last;
    logic busy;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/feature_point_dedup_by_radius.sv =====
// Top level of the radius-based feature point dedup block.
// Depends on fpdr_pkg, fpdr_ctrl, fpdr_datapath and fpdr_ram.
//
// Channel | Direction | Handshake             | Payload
// in_     | input     | in_tvalid/in_tready   | tuser: operation; tdata: point_x, point_y
// out_    | output    | out_tvalid/out_tready | tuser: is_new; tdata: index, kept_x, kept_y
// cfg_    | input     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// A query is resolved by the single distance comparator that walks the point store
// one entry per cycle; no new item is taken until the query's result is registered.
// Reset is synchronous on rst_n; the store needs no clearing pass.
// A stalled result stays in the output register; a further query waits only at its end.
module feature_point_dedup_by_radius #(
  parameter int MAX_POINTS = 512
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [15:0] point_x, [31:16] point_y
  input  logic [fpdr_pkg::IN_TDATA_W-1:0]       in_tdata,
  // [1:0] operation
  input  logic [fpdr_pkg::OP_W-1:0]             in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [19:0] assigned_index, [35:20] kept_x, [51:36] kept_y, [55:52] zero
  output logic [fpdr_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // [0] is_new
  output logic [fpdr_pkg::OUT_TUSER_W-1:0]      out_tuser,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fpdr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fpdr_pkg::CFG_DATA_W-1:0]       cfg_data
);

  fpdr_pkg::cmd_t  cmd;
  fpdr_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  fpdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (fpdr_pkg::op_t'(in_tuser)),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fpdr_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_x       (in_tdata[fpdr_pkg::COORD_W-1:0]),
    .in_y       (in_tdata[2*fpdr_pkg::COORD_W-1:fpdr_pkg::COORD_W]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== sv/fpdr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module fpdr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/fpdr_datapath.sv =====
// Datapath of the dedup block: point store, scan pipeline, config and result registers.
// Depends on fpdr_pkg, fpdr_ram and assert_macros.svh.
`include "assert_macros.svh"

module fpdr_datapath #(
  parameter int MAX_POINTS = 512
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  fpdr_pkg::cmd_t                       cmd,
  output fpdr_pkg::stat_t                      stat,
  input  logic                                 cfg_valid,
  input  logic [fpdr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fpdr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [fpdr_pkg::COORD_W-1:0]         in_x,
  input  logic [fpdr_pkg::COORD_W-1:0]         in_y,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [fpdr_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [fpdr_pkg::OUT_TUSER_W-1:0]     out_tuser
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int CRD = fpdr_pkg::COORD_W;
  localparam int SQW = fpdr_pkg::SQ_W;
  localparam int IXW = fpdr_pkg::IDX_W;
  localparam int PAD = fpdr_pkg::OUT_TDATA_W - IXW - 2 * CRD;

  // Configuration registers
  logic [CRD-1:0] thresh_r;
  logic [IXW-1:0] first_r;

  // Store bookkeeping
  logic [CW-1:0]                   store_cnt_r;
  logic [fpdr_pkg::KEPT_W-1:0]     kept_cnt_r;
  logic                            store_full;
  logic                            ram_we;
  logic [2*CRD-1:0]                ram_rdata;

  // Query and scan pipeline
  logic [CRD-1:0] qx_r, qy_r;
  logic [SQW-1:0] limit_r;
  logic [AW-1:0]  scan_addr_r;
  logic           v1_r, v2_r;
  logic [CRD-1:0] dx, dy;
  logic [SQW-1:0] sqx_r, sqy_r;
  logic [SQW:0]   dist2;
  logic           hit_r;

  // Result register
  logic           out_valid_r;
  logic           out_new_r;
  logic [IXW-1:0] out_idx_r;
  logic [CRD-1:0] out_x_r, out_y_r;

  assign store_full = (store_cnt_r == CW'(MAX_POINTS));
  assign ram_we     = cmd.load && !store_full;

  fpdr_ram #(
    .WIDTH (2 * CRD),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (store_cnt_r[AW-1:0]),
    .wdata ({in_y, in_x}),
    .re    (cmd.issue),
    .raddr (scan_addr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= fpdr_pkg::THRESH_RESET;
      first_r  <= fpdr_pkg::FIRST_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fpdr_pkg::REG_THRESHOLD:   thresh_r <= cfg_data[CRD-1:0];
        fpdr_pkg::REG_FIRST_INDEX: first_r  <= cfg_data[IXW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_cnt_r <= '0;
    end else if (cmd.clear) begin
      store_cnt_r <= '0;
    end else if (ram_we) begin
      store_cnt_r <= store_cnt_r + CW'(1);
    end
  end

  always_comb begin
    dx = (ram_rdata[CRD-1:0] >= qx_r) ? (ram_rdata[CRD-1:0] - qx_r)
                                      : (qx_r - ram_rdata[CRD-1:0]);
    dy = (ram_rdata[2*CRD-1:CRD] >= qy_r) ? (ram_rdata[2*CRD-1:CRD] - qy_r)
                                          : (qy_r - ram_rdata[2*CRD-1:CRD]);
    dist2 = {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  // Query capture and scan address
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qx_r        <= in_x;
      qy_r        <= in_y;
      limit_r     <= {{CRD{1'b0}}, thresh_r} * {{CRD{1'b0}}, thresh_r};
      scan_addr_r <= '0;
    end else if (cmd.issue) begin
      scan_addr_r <= scan_addr_r + AW'(1);
    end
    if (v1_r) begin
      sqx_r <= {{CRD{1'b0}}, dx} * {{CRD{1'b0}}, dx};
      sqy_r <= {{CRD{1'b0}}, dy} * {{CRD{1'b0}}, dy};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      if (cmd.start) begin
        hit_r <= 1'b0;
      end else if (v2_r && (dist2 <= {1'b0, limit_r})) begin
        hit_r <= 1'b1;
      end
    end
  end

  // Kept count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        kept_cnt_r <= '0;
      end else if (cmd.emit && !hit_r) begin
        kept_cnt_r <= kept_cnt_r + fpdr_pkg::KEPT_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_new_r <= !hit_r;
      out_idx_r <= hit_r ? '0 : (first_r + IXW'(kept_cnt_r));
      out_x_r   <= qx_r;
      out_y_r   <= qy_r;
    end
  end

  assign stat.empty    = (store_cnt_r == '0);
  assign stat.last     = ((CW'(scan_addr_r) + CW'(1)) == store_cnt_r);
  assign stat.busy     = v1_r || v2_r;
  assign stat.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD{1'b0}}, out_y_r, out_x_r, out_idx_r};
  assign out_tuser  = out_new_r;

  `ASSERT_ALWAYS(a_store_cnt_max, store_cnt_r <= CW'(MAX_POINTS), "store count above capacity")
  `ASSERT_IMPLY(a_read_in_range, cmd.issue, CW'(scan_addr_r) < store_cnt_r, "scan past store")
  `ASSERT_IMPLY(a_emit_no_overwrite, cmd.emit, stat.out_free, "result overwritten")

endmodule

// ===== sv/fpdr_ctrl.sv =====
// Controller of the dedup block: decodes input items and sequences the store scan.
// Depends on fpdr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fpdr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  fpdr_pkg::op_t   in_op,
  output logic            in_tready,
  input  fpdr_pkg::stat_t stat,
  output fpdr_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            fpdr_pkg::OP_CLEAR: cmd.clear = 1'b1;
            fpdr_pkg::OP_LOAD:  cmd.load  = 1'b1;
            fpdr_pkg::OP_QUERY: begin
              cmd.start = 1'b1;
              state_nxt = stat.empty ? S_EMIT : S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // one stored point per cycle
        cmd.issue = 1'b1;
        if (stat.last) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        // drain the distance pipeline
        if (!stat.busy) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_NEXT(a_emit_to_idle, cmd.emit, in_tready, "no return to idle after result")
  `ASSERT_IMPLY(a_emit_drained, cmd.emit, !stat.busy, "result taken before scan drained")

endmodule

// ===== dv/dedup_checker.sv =====
// Checker for the radius-based feature point dedup block: mirrors the point store,
// the kept counter and both registers, predicts every query verdict and compares it.
// Depends on fpdr_pkg only; watches the in_, out_ and cfg_ channels of the block.
module dedup_checker
  import fpdr_pkg::*;
#(
  parameter int MAX_POINTS = 512
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [OP_W-1:0]        in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [OUT_TUSER_W-1:0] out_tuser,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending,
  output int                     checked_count,
  output int                     kept_seen
);

  typedef struct packed {
    logic               is_new;
    logic [IDX_W-1:0]   index;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } verdict_t;

  logic [COORD_W-1:0] track_x [MAX_POINTS];
  logic [COORD_W-1:0] track_y [MAX_POINTS];
  logic [KEPT_W-1:0]  track_cnt;
  logic [KEPT_W-1:0]  kept_cnt;
  logic [COORD_W-1:0] radius;
  logic [IDX_W-1:0]   base_index;
  verdict_t           verdict_q[$];

  function automatic logic [SQ_W-1:0] sq_gap(input logic [COORD_W-1:0] a, b);
    logic [SQ_W-1:0] d;
    d = (a >= b) ? a - b : b - a;
    return d * d;
  endfunction

  // Close means squared distance at most radius squared; 33 bits hold every sum.
  function automatic logic near_tracked(input logic [COORD_W-1:0] x, y);
    logic [SQ_W:0] limit_sq;
    logic [SQ_W:0] dist_sq;
    int            k;
    limit_sq = sq_gap(radius, '0);
    for (k = 0; k < int'(track_cnt); k++) begin
      dist_sq = sq_gap(track_x[k], x) + sq_gap(track_y[k], y);
      if (dist_sq <= limit_sq) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic verdict_t judge_query(input logic [COORD_W-1:0] x, y);
    verdict_t v;
    v.is_new = !near_tracked(x, y);
    v.index  = '0;
    v.x      = x;
    v.y      = y;
    if (v.is_new) begin
      v.index  = base_index + IDX_W'(kept_cnt);
      kept_cnt = kept_cnt + 1'b1;
    end
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t           want;
    verdict_t           got;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    if (!rst_n) begin
      track_cnt     = '0;
      kept_cnt      = '0;
      radius        = THRESH_RESET;
      base_index    = FIRST_RESET;
      fail_count    = 0;
      checked_count = 0;
      kept_seen     = 0;
      verdict_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THRESHOLD:   radius = cfg_data[COORD_W-1:0];
          REG_FIRST_INDEX: base_index = cfg_data[IDX_W-1:0];
          default: ;
        endcase
      end

      if (out_tvalid && out_tready) begin
        got.is_new = out_tuser[0];
        got.index  = out_tdata[IDX_W-1:0];
        got.x      = out_tdata[IDX_W +: COORD_W];
        got.y      = out_tdata[IDX_W+COORD_W +: COORD_W];
        checked_count++;
        if (got.is_new) kept_seen++;
        if (verdict_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result is_new=%0d index=%05h x=%04h y=%04h",
                   $time, got.is_new, got.index, got.x, got.y);
        end else begin
          want = verdict_q.pop_front();
          if (got.is_new !== want.is_new || got.index !== want.index ||
              got.x !== want.x || got.y !== want.y) begin
            fail_count++;
            $display("%0t: result mismatch: expected is_new=%0d index=%05h x=%04h y=%04h",
                     $time, want.is_new, want.index, want.x, want.y);
            $display("%0t:                  actual   is_new=%0d index=%05h x=%04h y=%04h",
                     $time, got.is_new, got.index, got.x, got.y);
          end
        end
      end

      if (in_tvalid && in_tready) begin
        px = in_tdata[COORD_W-1:0];
        py = in_tdata[2*COORD_W-1:COORD_W];
        case (in_tuser)
          OP_CLEAR: begin
            track_cnt = '0;
            kept_cnt  = '0;
          end
          OP_LOAD: begin
            // drop loads once the store is full
            if (int'(track_cnt) < MAX_POINTS) begin
              track_x[track_cnt] = px;
              track_y[track_cnt] = py;
              track_cnt          = track_cnt + 1'b1;
            end
          end
          OP_QUERY: verdict_q.push_back(judge_query(px, py));
          default: ;
        endcase
      end
    end
    pending = verdict_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the dedup block's testbench: clock, reset, stimulus and the final verdict.
// Depends on fpdr_pkg, feature_point_dedup_by_radius and dedup_checker.
module testbench;
  import fpdr_pkg::*;

  localparam int          MAX_POINTS  = 512;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;  // unused code, the block drops it

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [OP_W-1:0]        in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  int                 fail_count;
  int                 pending;
  int                 checked_count;
  int                 kept_seen;
  int unsigned        cycle_count = 0;
  int                 sent_count  = 0;
  int                 stall_left  = 0;
  logic               calm        = 1'b0;  // no idling on either side while set
  logic [COORD_W-1:0] cur_radius  = THRESH_RESET;
  logic [COORD_W-1:0] held_x[$];           // points the store should hold, for aiming queries
  logic [COORD_W-1:0] held_y[$];

  feature_point_dedup_by_radius #(.MAX_POINTS(MAX_POINTS)) u_top (.*);
  dedup_checker #(.MAX_POINTS(MAX_POINTS)) u_checker (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result sink: stall at random, except during calm stretches.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 30) stall_left <= idle_len();
    end
  end

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return COORD_W'($urandom_range(0, 15));
      1:       return COORD_W'($urandom_range(16'hFFF0, 16'hFFFF));
      default: return COORD_W'($urandom());
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] nudge(input logic [COORD_W-1:0] c, input int span);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return COORD_W'(v);
  endfunction

  function automatic logic [COORD_W-1:0] pick_radius();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return COORD_W'($urandom_range(1, 32));
      3:       return THRESH_RESET;
      4:       return COORD_W'($urandom());
      default: return COORD_W'($urandom_range(0, 2000));
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_first();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 20'hFFFFF;
      2:       return IDX_W'($urandom_range(20'hFFF00, 20'hFFFFF));
      default: return IDX_W'($urandom_range(0, 20'hFFFFF));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] x, y);
    int gap;
    gap = (calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {y, x};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sent_count++;
    if (op == OP_CLEAR) begin
      held_x.delete();
      held_y.delete();
    end else if (op == OP_LOAD && held_x.size() < MAX_POINTS) begin
      held_x.push_back(x);
      held_y.push_back(y);
    end
  endtask

  // Hold the sender until every result is back, then let the block go idle.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic configure(input logic [COORD_W-1:0] thr, input logic [IDX_W-1:0] first);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_data  <= CFG_DATA_W'(thr);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= REG_FIRST_INDEX;
    cfg_data  <= first;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid  <= 1'b0;
    cur_radius = thr;
  endtask

  task automatic load_point();
    int k;
    if (held_x.size() > 0 && $urandom_range(0, 3) == 0) begin
      k = $urandom_range(0, held_x.size() - 1);
      send_item(OP_LOAD, nudge(held_x[k], 3 * int'(cur_radius) + 4),
                nudge(held_y[k], 3 * int'(cur_radius) + 4));
    end else begin
      send_item(OP_LOAD, rand_coord(), rand_coord());
    end
  endtask

  // Aim a query at a held point: exact copy, on the radius, or somewhere around it.
  task automatic query_near();
    int                 k;
    int                 span;
    logic [COORD_W-1:0] qx;
    logic [COORD_W-1:0] qy;
    if (held_x.size() == 0) begin
      send_item(OP_QUERY, rand_coord(), rand_coord());
      return;
    end
    k    = $urandom_range(0, held_x.size() - 1);
    span = int'(cur_radius) + int'(cur_radius) / 4 + 2;
    qx   = nudge(held_x[k], span);
    qy   = nudge(held_y[k], span);
    case ($urandom_range(0, 3))
      0: begin
        qx = held_x[k];
        qy = held_y[k];
      end
      1: begin
        qy = held_y[k];
        if (int'(held_x[k]) + int'(cur_radius) <= 65535) qx = held_x[k] + cur_radius;
        else if (held_x[k] >= cur_radius) qx = held_x[k] - cur_radius;
      end
      default: ;
    endcase
    send_item(OP_QUERY, qx, qy);
  endtask

  task automatic mixed_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) send_item(OP_IGNORED, COORD_W'($urandom()), COORD_W'($urandom()));
    else if (r < 10) send_item(OP_W'($urandom_range(0, 3)), rand_coord(), rand_coord());
    else if (r < 55) query_near();
    else send_item(OP_QUERY, rand_coord(), rand_coord());
  endtask

  initial begin
    int                 n;
    int                 r;
    logic [COORD_W-1:0] lost_x;
    logic [COORD_W-1:0] lost_y;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed cases at reset settings: radius 240, first index 0.
    send_item(OP_QUERY, 16'd0, 16'd0);             // empty store, always new
    send_item(OP_IGNORED, 16'hFFFF, 16'hFFFF);
    send_item(OP_LOAD, 16'd0, 16'd0);
    send_item(OP_LOAD, 16'hFFFF, 16'hFFFF);
    send_item(OP_QUERY, 16'd240, 16'd0);           // exactly on the radius
    send_item(OP_QUERY, 16'd241, 16'd0);           // one step outside
    send_item(OP_QUERY, 16'hFFFF - 16'd144, 16'hFFFF - 16'd192);  // 144,192 lies on 240
    send_item(OP_QUERY, 16'hFFFF - 16'd145, 16'hFFFF - 16'd192);
    send_item(OP_QUERY, 16'h8000, 16'h7FFF);
    send_item(OP_CLEAR, 16'h1234, 16'h5678);
    send_item(OP_QUERY, 16'd0, 16'd0);             // kept count restarts
    configure(16'hFFFF, 20'hFFFFE);
    send_item(OP_LOAD, 16'd0, 16'd0);
    send_item(OP_QUERY, 16'hFFFF, 16'hFFFF);       // widest distance there is
    send_item(OP_QUERY, 16'hFFFF, 16'd0);          // on the largest radius
    send_item(OP_QUERY, 16'hFFFF, 16'd1);          // index wraps past 20 bits
    configure(16'd0, 20'h5A5A5);
    send_item(OP_LOAD, 16'hA5A5, 16'h5A5A);
    send_item(OP_QUERY, 16'hA5A5, 16'h5A5A);       // zero radius still matches itself
    send_item(OP_QUERY, 16'hA5A6, 16'h5A5A);
    send_item(OP_CLEAR, 16'd0, 16'd0);

    // Mixed traffic with frequent clears and register changes.
    repeat (20) begin
      calm = ($urandom_range(0, 3) == 0);
      r    = $urandom_range(0, 7);
      if (r < 2) configure(pick_radius(), pick_first());
      else if (r == 2) settle();
      if ($urandom_range(0, 2) == 0) send_item(OP_CLEAR, rand_coord(), rand_coord());
      repeat ($urandom_range(0, 10)) load_point();
      repeat ($urandom_range(1, 8)) mixed_item();
    end

    // Full store: the last loads are dropped and must never match.
    calm = 1'b0;
    configure(COORD_W'($urandom_range(16, 400)), pick_first());
    send_item(OP_CLEAR, rand_coord(), rand_coord());
    repeat (MAX_POINTS) load_point();
    repeat (4) begin
      lost_x = COORD_W'($urandom());
      lost_y = COORD_W'($urandom());
      send_item(OP_LOAD, lost_x, lost_y);
    end
    send_item(OP_QUERY, lost_x, lost_y);
    send_item(OP_QUERY, held_x[MAX_POINTS-1], held_y[MAX_POINTS-1]);
    send_item(OP_QUERY, held_x[0], held_y[0]);
    repeat (3) query_near();

    // Long run without a clear so the assigned index wraps; the store stays small.
    configure(COORD_W'($urandom_range(0, 64)), IDX_W'($urandom_range(20'hFFF00, 20'hFFFFF)));
    send_item(OP_CLEAR, rand_coord(), rand_coord());
    for (n = 0; n < 430; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 2) == 0);
      if (n % 300 == 299) configure(COORD_W'($urandom_range(0, 64)), pick_first());
      r = $urandom_range(0, 99);
      if (r < 2 && held_x.size() < 24) load_point();
      else if (r < 5) send_item(OP_IGNORED, COORD_W'($urandom()), COORD_W'($urandom()));
      else if (r < 12) query_near();
      else send_item(OP_QUERY, rand_coord(), rand_coord());
    end

    calm = 1'b0;
    settle();
    repeat (40) @(negedge clk);
    $display("Sent %0d items: edge cases, mixed clear/load/query traffic, a full store",
             sent_count);
    $display("and a long run past the top of the index range; %0d results checked, %0d new, %0d failures",
             checked_count, kept_seen, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
